// ===== hdl/lfpd_pkg.sv =====
// Shared types and constants for the line-follow PID drive unit.
`timescale 1ns / 1ps

package lfpd_pkg;

    // Field widths
    localparam int SAMPLE_W    = 12;
    localparam int TARGET_W    = 12;
    localparam int CUTOFF_W    = 13;
    localparam int CMD_W       = 11;
    localparam int GAIN_W      = 12;
    localparam int LIMIT_W     = 12;
    localparam int ERR_W       = 13;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    // PID accumulator width: |acc| stays below 2^26
    localparam int ACC_W = 28;

    // Drive command constants
    localparam logic [CMD_W-1:0] STOP_COMMAND  = 11'd1000;
    localparam logic [CMD_W-1:0] REVERSE_PIVOT = 11'd2000;

    // Register reset values
    localparam logic [TARGET_W-1:0] TARGET_RESET = 12'd1925;
    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 13'd1700;
    localparam logic [CMD_W-1:0]    BASE_RESET   = 11'd1250;
    localparam logic [CMD_W-1:0]    MAX_RESET    = 11'd1900;
    localparam logic [GAIN_W-1:0]   GAIN_P_RESET = 12'd97;
    localparam logic [GAIN_W-1:0]   GAIN_I_RESET = 12'd0;
    localparam logic [GAIN_W-1:0]   GAIN_D_RESET = 12'd41;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 12'd100;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TARGET_LEVEL   = 3'd0,
        CFG_CUTOFF_LEVEL   = 3'd1,
        CFG_BASE_COMMAND   = 3'd2,
        CFG_MAX_COMMAND    = 3'd3,
        CFG_GAIN_P         = 3'd4,
        CFG_GAIN_I         = 3'd5,
        CFG_GAIN_D         = 3'd6,
        CFG_INTEGRAL_LIMIT = 3'd7
    } cfg_reg_t;

endpackage

// ===== hdl/line_follow_pid_drive_unit.sv =====
// Line-follow PID drive unit: sensor sample in, two motor drive commands out.
`timescale 1ns / 1ps

// The unit accepts one 12-bit line-sensor sample per item and returns one
// result item holding the left and right motor direction and drive value,
// a stop flag and the signed tracking error. It takes one item every cycle
// while the result channel does not stall. The sample is held in an input
// register, and one combinational pass (error, cutoff test, integral clamp,
// three gain multipliers in parallel, truncating scale, command clamps) feeds
// the result register. The integral and previous-error state is updated as
// each item that does not stop enters the result register, so back-to-back
// items see the state left by the last item that did not stop. The result
// register decouples the two channels; the sample channel stalls only while
// a result waits and the input register is full. Configuration writes are
// taken at any time (ready is held high) but are meant to be done while no
// item is in flight.
module line_follow_pid_drive_unit
    import lfpd_pkg::*;
#(
    parameter int SAMPLE_BITS    = 12,
    parameter int GAIN_FRAC_BITS = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    // Configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,

    // Sample channel
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic [SAMPLE_W-1:0]           sensor_sample,

    // Result channel
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          left_forward,
    output logic [CMD_W-1:0]              left_drive,
    output logic                          right_forward,
    output logic [CMD_W-1:0]              right_drive,
    output logic                          stopped,
    output logic signed [ERR_W-1:0]       error_value
);

    localparam int USED_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << USED_BITS) - 1);
    localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'((1 << GAIN_FRAC_BITS) - 1);
    localparam int PROD_W = GAIN_W + ERR_W + 2;

    typedef struct packed {
        logic             forward;
        logic [CMD_W-1:0] drive;
    } drive_t;

    // Clamp a command to 0..limit and map it to direction and drive value
    function automatic drive_t drive_side(input logic signed [ACC_W:0] cmd,
                                          input logic [CMD_W-1:0] limit);
        logic [CMD_W-1:0] clamped;
        drive_t           d;
        if (cmd[ACC_W])
        begin
            clamped = '0;
        end
        else if (cmd > $signed({{(ACC_W + 1 - CMD_W){1'b0}}, limit}))
        begin
            clamped = limit;
        end
        else
        begin
            clamped = cmd[CMD_W-1:0];
        end
        if (clamped >= STOP_COMMAND)
        begin
            d.forward = 1'b1;
            d.drive   = clamped;
        end
        else
        begin
            d.forward = 1'b0;
            d.drive   = REVERSE_PIVOT - clamped;
        end
        return d;
    endfunction

    // Configuration registers
    logic [TARGET_W-1:0] target_level_reg;
    logic [CUTOFF_W-1:0] cutoff_level_reg;
    logic [CMD_W-1:0]    base_command_reg;
    logic [CMD_W-1:0]    max_command_reg;
    logic [GAIN_W-1:0]   gain_p_reg;
    logic [GAIN_W-1:0]   gain_i_reg;
    logic [GAIN_W-1:0]   gain_d_reg;
    logic [LIMIT_W-1:0]  integral_limit_reg;

    // Controller state
    logic signed [ERR_W-1:0] integral_sum_reg;
    logic signed [ERR_W-1:0] previous_error_reg;

    // Input register
    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;

    // Result register
    logic                    out_valid_reg;
    logic                    left_forward_reg;
    logic [CMD_W-1:0]        left_drive_reg;
    logic                    right_forward_reg;
    logic [CMD_W-1:0]        right_drive_reg;
    logic                    stopped_reg;
    logic signed [ERR_W-1:0] error_value_reg;

    // Datapath signals
    logic                    out_advance;
    logic                    move_item;
    logic                    take_sample;
    logic signed [ERR_W-1:0] err;
    logic [ERR_W-1:0]        err_mag;
    logic                    stop_now;
    logic signed [ERR_W:0]   isum;
    logic signed [ERR_W:0]   lim_pos;
    logic signed [ERR_W-1:0] integ;
    logic signed [ERR_W:0]   deriv;
    logic signed [PROD_W-1:0] prod_p;
    logic signed [PROD_W-1:0] prod_i;
    logic signed [PROD_W-1:0] prod_d;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_biased;
    logic signed [ACC_W-1:0] pid;
    logic signed [ACC_W:0]   left_cmd;
    logic signed [ACC_W:0]   right_cmd;
    drive_t                  left_d;
    drive_t                  right_d;

    // Handshake
    assign cfg_ready    = 1'b1;
    assign out_advance  = !out_valid_reg || !result_stall;
    assign move_item    = in_valid_reg && out_advance;
    assign sample_stall = in_valid_reg && !out_advance;
    assign take_sample  = sample_valid && !sample_stall;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_level_reg   <= TARGET_RESET;
            cutoff_level_reg   <= CUTOFF_RESET;
            base_command_reg   <= BASE_RESET;
            max_command_reg    <= MAX_RESET;
            gain_p_reg         <= GAIN_P_RESET;
            gain_i_reg         <= GAIN_I_RESET;
            gain_d_reg         <= GAIN_D_RESET;
            integral_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_TARGET_LEVEL:   target_level_reg   <= cfg_data[TARGET_W-1:0];
                CFG_CUTOFF_LEVEL:   cutoff_level_reg   <= cfg_data[CUTOFF_W-1:0];
                CFG_BASE_COMMAND:   base_command_reg   <= cfg_data[CMD_W-1:0];
                CFG_MAX_COMMAND:    max_command_reg    <= cfg_data[CMD_W-1:0];
                CFG_GAIN_P:         gain_p_reg         <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:         gain_i_reg         <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:         gain_d_reg         <= cfg_data[GAIN_W-1:0];
                CFG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:            ;
            endcase
        end
    end

    // Error and cutoff test
    always_comb
    begin
        err      = $signed({1'b0, target_level_reg}) - $signed({1'b0, in_sample_reg});
        err_mag  = err[ERR_W-1] ? ERR_W'(-err) : err;
        stop_now = (err_mag >= cutoff_level_reg);
    end

    // Clamp the integral and form the derivative
    always_comb
    begin
        isum    = (ERR_W + 1)'(integral_sum_reg) + (ERR_W + 1)'(err);
        lim_pos = $signed({2'b00, integral_limit_reg});
        if (isum > lim_pos)
        begin
            integ = lim_pos[ERR_W-1:0];
        end
        else if (isum < -lim_pos)
        begin
            integ = ERR_W'(-lim_pos);
        end
        else
        begin
            integ = isum[ERR_W-1:0];
        end
        deriv = (ERR_W + 1)'(err) - (ERR_W + 1)'(previous_error_reg);
    end

    // Three gain products, sum, truncate toward zero
    always_comb
    begin
        prod_p     = PROD_W'($signed({1'b0, gain_p_reg})) * PROD_W'(err);
        prod_i     = PROD_W'($signed({1'b0, gain_i_reg})) * PROD_W'(integ);
        prod_d     = PROD_W'($signed({1'b0, gain_d_reg})) * PROD_W'(deriv);
        acc        = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
        acc_biased = acc[ACC_W-1] ? acc + $signed(ROUND_BIAS) : acc;
        pid        = acc_biased >>> GAIN_FRAC_BITS;
    end

    // Side commands and drive mapping
    always_comb
    begin
        if (stop_now)
        begin
            left_cmd  = $signed({{(ACC_W + 1 - CMD_W){1'b0}}, STOP_COMMAND});
            right_cmd = $signed({{(ACC_W + 1 - CMD_W){1'b0}}, STOP_COMMAND});
        end
        else
        begin
            left_cmd  = $signed({{(ACC_W + 1 - CMD_W){1'b0}}, base_command_reg})
                        - (ACC_W + 1)'(pid);
            right_cmd = $signed({{(ACC_W + 1 - CMD_W){1'b0}}, base_command_reg})
                        + (ACC_W + 1)'(pid);
        end
        left_d  = drive_side(left_cmd, max_command_reg);
        right_d = drive_side(right_cmd, max_command_reg);
    end

    // Hold or advance the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take_sample)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (move_item)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            in_sample_reg <= sensor_sample & SAMPLE_MASK;
        end
    end

    // Update controller state as an item completes, unless it stopped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_sum_reg   <= '0;
            previous_error_reg <= '0;
        end
        else if (move_item && !stop_now)
        begin
            integral_sum_reg   <= integ;
            previous_error_reg <= err;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (move_item)
        begin
            left_forward_reg  <= left_d.forward;
            left_drive_reg    <= left_d.drive;
            right_forward_reg <= right_d.forward;
            right_drive_reg   <= right_d.drive;
            stopped_reg       <= stop_now;
            error_value_reg   <= err;
        end
    end

    assign result_valid  = out_valid_reg;
    assign left_forward  = left_forward_reg;
    assign left_drive    = left_drive_reg;
    assign right_forward = right_forward_reg;
    assign right_drive   = right_drive_reg;
    assign stopped       = stopped_reg;
    assign error_value   = error_value_reg;

endmodule

// ===== hdl/lfpd_checker.sv =====
// Port-level checker for the line-follow PID drive unit, with its bind.
`timescale 1ns / 1ps

module lfpd_checker
    import lfpd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             sample_stall,
    input logic             result_valid,
    input logic             result_stall,
    input logic             left_forward,
    input logic [CMD_W-1:0] left_drive,
    input logic             right_forward,
    input logic [CMD_W-1:0] right_drive,
    input logic             stopped
);

    // A stopped item commands both sides identically
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && stopped |->
            left_forward == right_forward && left_drive == right_drive)
    else $error("stopped item with unequal side commands");

    // Left drive value agrees with its direction
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (left_forward && left_drive >= STOP_COMMAND) ||
            (!left_forward && left_drive > STOP_COMMAND && left_drive <= REVERSE_PIVOT))
    else $error("left drive out of range for its direction");

    // Right drive value agrees with its direction
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (right_forward && right_drive >= STOP_COMMAND) ||
            (!right_forward && right_drive > STOP_COMMAND && right_drive <= REVERSE_PIVOT))
    else $error("right drive out of range for its direction");

    // Sample stall arises only from a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> result_valid && result_stall)
    else $error("sample channel stalled without a waiting result");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(left_drive) && $stable(right_drive) && $stable(stopped))
    else $error("stalled result changed");

endmodule

bind line_follow_pid_drive_unit lfpd_checker u_lfpd_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the line-follow PID drive unit.
`timescale 1ns / 1ps

module tb;
    import lfpd_pkg::*;

    localparam int GAIN_FRAC     = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct {
        logic                    left_forward;
        logic [CMD_W-1:0]        left_drive;
        logic                    right_forward;
        logic [CMD_W-1:0]        right_drive;
        logic                    stopped;
        logic signed [ERR_W-1:0] error_value;
    } drive_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    logic                    sample_valid = 1'b0;
    logic                    sample_stall;
    logic [SAMPLE_W-1:0]     sensor_sample = '0;

    logic                    result_valid;
    logic                    result_stall = 1'b0;
    logic                    left_forward;
    logic [CMD_W-1:0]        left_drive;
    logic                    right_forward;
    logic [CMD_W-1:0]        right_drive;
    logic                    stopped;
    logic signed [ERR_W-1:0] error_value;

    // Register copies and controller state for prediction
    logic [TARGET_W-1:0] target_q  = TARGET_RESET;
    logic [CUTOFF_W-1:0] cutoff_q  = CUTOFF_RESET;
    logic [CMD_W-1:0]    base_q    = BASE_RESET;
    logic [CMD_W-1:0]    max_q     = MAX_RESET;
    logic [GAIN_W-1:0]   kp_q      = GAIN_P_RESET;
    logic [GAIN_W-1:0]   ki_q      = GAIN_I_RESET;
    logic [GAIN_W-1:0]   kd_q      = GAIN_D_RESET;
    logic [LIMIT_W-1:0]  ilimit_q  = LIMIT_RESET;
    longint              integ_state = 0;
    longint              last_error  = 0;

    drive_result_t pending_drives[$];
    int            mismatches  = 0;
    int            cycle_count = 0;
    bit            steady_run  = 1'b0;

    line_follow_pid_drive_unit #(
        .SAMPLE_BITS    (SAMPLE_W),
        .GAIN_FRAC_BITS (GAIN_FRAC)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .sensor_sample (sensor_sample),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .left_forward  (left_forward),
        .left_drive    (left_drive),
        .right_forward (right_forward),
        .right_drive   (right_drive),
        .stopped       (stopped),
        .error_value   (error_value)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Stall the result side now and then, except in steady stretches
    always @(posedge clk)
    begin
        result_stall <= !steady_run && ($urandom_range(0, 99) < 7);
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // Clamp one side command and turn it into direction and drive magnitude
    function automatic void side_drive(input longint command, output logic fwd,
                                       output logic [CMD_W-1:0] mag);
        longint clamped;
        longint pivot_diff;
        clamped = command;
        if (clamped > longint'(max_q))
            clamped = longint'(max_q);
        if (clamped < 0)
            clamped = 0;
        if (clamped >= longint'(STOP_COMMAND))
        begin
            fwd = 1'b1;
            mag = clamped[CMD_W-1:0];
        end
        else
        begin
            fwd = 1'b0;
            pivot_diff = longint'(REVERSE_PIVOT) - clamped;
            mag = pivot_diff[CMD_W-1:0];
        end
    endfunction

    // Work out the drive result of one sample and advance the controller state
    function automatic drive_result_t predict_drive(input logic [SAMPLE_W-1:0] s);
        drive_result_t r;
        longint err;
        longint mag;
        longint lim;
        longint integ;
        longint deriv;
        longint acc;
        longint pid;
        err = longint'(target_q) - longint'(s);
        mag = (err < 0) ? -err : err;
        r.error_value = err[ERR_W-1:0];
        if (mag >= longint'(cutoff_q))
        begin
            r.stopped = 1'b1;
            side_drive(longint'(STOP_COMMAND), r.left_forward, r.left_drive);
            side_drive(longint'(STOP_COMMAND), r.right_forward, r.right_drive);
        end
        else
        begin
            lim = longint'(ilimit_q);
            integ = integ_state + err;
            if (integ > lim)
                integ = lim;
            if (integ < -lim)
                integ = -lim;
            deriv = err - last_error;
            acc = longint'(kp_q) * err + longint'(ki_q) * integ + longint'(kd_q) * deriv;
            // Integer division truncates toward zero
            pid = acc / (longint'(1) << GAIN_FRAC);
            integ_state = integ;
            last_error = err;
            r.stopped = 1'b0;
            side_drive(longint'(base_q) - pid, r.left_forward, r.left_drive);
            side_drive(longint'(base_q) + pid, r.right_forward, r.right_drive);
        end
        return r;
    endfunction

    // Compare each result item with the oldest prediction
    always @(posedge clk)
    begin
        drive_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_drives.size() == 0)
                report_mismatch("result item with no sample pending");
            else
            begin
                want = pending_drives.pop_front();
                check_field("left_forward", 32'(left_forward), 32'(want.left_forward));
                check_field("left_drive", 32'(left_drive), 32'(want.left_drive));
                check_field("right_forward", 32'(right_forward), 32'(want.right_forward));
                check_field("right_drive", 32'(right_drive), 32'(want.right_drive));
                check_field("stopped", 32'(stopped), 32'(want.stopped));
                check_field("error_value", 32'(error_value), 32'(want.error_value));
            end
        end
    end

    // Send one sample item, with random idle cycles ahead of it
    task automatic send_sample(input int unsigned value);
        logic [SAMPLE_W-1:0] s;
        s = value[SAMPLE_W-1:0];
        while (!steady_run && $urandom_range(0, 99) < 7)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid  <= 1'b1;
        sensor_sample <= s;
        do
            @(posedge clk);
        while (sample_stall);
        pending_drives.push_back(predict_drive(s));
    endtask

    // Hold off new samples until every result item is back
    task automatic drain_results();
        sample_valid <= 1'b0;
        while (pending_drives.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_reg_t idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_TARGET_LEVEL:   target_q = value[TARGET_W-1:0];
            CFG_CUTOFF_LEVEL:   cutoff_q = value[CUTOFF_W-1:0];
            CFG_BASE_COMMAND:   base_q   = value[CMD_W-1:0];
            CFG_MAX_COMMAND:    max_q    = value[CMD_W-1:0];
            CFG_GAIN_P:         kp_q     = value[GAIN_W-1:0];
            CFG_GAIN_I:         ki_q     = value[GAIN_W-1:0];
            CFG_GAIN_D:         kd_q     = value[GAIN_W-1:0];
            CFG_INTEGRAL_LIMIT: ilimit_q = value[LIMIT_W-1:0];
            default:            ;
        endcase
    endtask

    // Drain, then write all eight registers
    task automatic apply_settings(input int unsigned target, input int unsigned cutoff,
                                  input int unsigned base, input int unsigned max_cmd,
                                  input int unsigned kp, input int unsigned ki,
                                  input int unsigned kd, input int unsigned limit);
        drain_results();
        write_register(CFG_TARGET_LEVEL, target);
        write_register(CFG_CUTOFF_LEVEL, cutoff);
        write_register(CFG_BASE_COMMAND, base);
        write_register(CFG_MAX_COMMAND, max_cmd);
        write_register(CFG_GAIN_P, kp);
        write_register(CFG_GAIN_I, ki);
        write_register(CFG_GAIN_D, kd);
        write_register(CFG_INTEGRAL_LIMIT, limit);
        cfg_valid <= 1'b0;
    endtask

    // Mostly a working value, sometimes an extreme of the register or any value in its range
    function automatic int unsigned pick_value(input int unsigned lo, input int unsigned hi,
                                               input int unsigned top);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(lo, hi);
        if (r < 87)
            return 0;
        if (r < 94)
            return top;
        return $urandom_range(0, top);
    endfunction

    // Mostly samples near the line, with cutoff edges, full range and extremes
    function automatic int unsigned random_sample();
        int r;
        int s;
        r = $urandom_range(0, 99);
        if (r < 60)
            s = int'(target_q) + int'($urandom_range(0, 800)) - 400;
        else if (r < 70)
            s = int'(target_q) + ($urandom_range(0, 1) ? 1 : -1)
                * (int'(cutoff_q) - int'($urandom_range(0, 1)));
        else if (r < 92)
            s = $urandom_range(0, 4095);
        else
            s = $urandom_range(0, 1) ? 4095 : 0;
        if (s < 0)
            s = 0;
        if (s > 4095)
            s = 4095;
        return s;
    endfunction

    // Reset settings: on the line, cutoff edges and far off
    task automatic test_default_settings();
        send_sample(1925);
        send_sample(226);
        send_sample(225);
        send_sample(3624);
        send_sample(3625);
        send_sample(0);
        send_sample(4095);
        send_sample(2000);
    endtask

    // Stop value clamped by a max below 1000, and zero cutoff stops everything
    task automatic test_stop_small_max();
        apply_settings(1925, 0, 1250, 500, 97, 0, 41, 100);
        send_sample(1925);
        send_sample(0);
        apply_settings(1925, 0, 1250, 0, 97, 0, 41, 100);
        send_sample(4095);
    endtask

    // Negative command clamps to zero; max above 2000 drives forward
    task automatic test_command_clamps();
        apply_settings(2048, 4096, 0, 2047, 4095, 0, 0, 100);
        send_sample(0);
        send_sample(4095);
        apply_settings(2048, 4096, 2047, 2047, 0, 0, 0, 100);
        send_sample(2048);
    endtask

    // Drive the integral into both limits
    task automatic test_integral_clamp();
        apply_settings(2000, 4096, 1000, 2000, 0, 256, 0, 50);
        repeat (3) send_sample(1900);
        repeat (3) send_sample(2100);
    endtask

    // All registers at their top, then all at zero
    task automatic test_register_extremes();
        apply_settings(4095, 8191, 2047, 2047, 4095, 4095, 4095, 4095);
        send_sample(0);
        send_sample(4095);
        apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
        send_sample(4095);
    endtask

    // Random settings per phase, random samples within
    task automatic test_random_traffic();
        for (int phase = 0; phase < 9; phase++)
        begin
            steady_run = 1'b0;
            apply_settings(pick_value(500, 3500, 4095), pick_value(100, 2500, 8191),
                           pick_value(800, 1700, 2047), pick_value(1000, 2047, 2047),
                           pick_value(0, 300, 4095), pick_value(0, 200, 4095),
                           pick_value(0, 300, 4095), pick_value(0, 1000, 4095));
            steady_run = (phase == 4);
            for (int n = 0; n < 105; n++)
            begin
                if (phase == 1 && n == 50)
                    drain_results();
                send_sample(random_sample());
            end
        end
        steady_run = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_settings();
        test_stop_small_max();
        test_command_clamps();
        test_integral_clamp();
        test_register_extremes();
        test_random_traffic();

        drain_results();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
